// ----- rtl/mhc_pkg.sv -----
// Package for the magnetometer heading calibrator: payload structs, FSM states,
// and the arctangent constant table. No dependencies.
`timescale 1ns / 1ps
package mhc_pkg;

    typedef struct packed {
        logic       mode;
        logic [7:0] x_high_byte;
        logic [7:0] x_low_byte;
        logic [7:0] z_high_byte;
        logic [7:0] z_low_byte;
        logic [7:0] y_high_byte;
        logic [7:0] y_low_byte;
    } in_item_t;

    typedef struct packed {
        logic [15:0]        heading;
        logic signed [15:0] cal_x;
        logic signed [15:0] cal_y;
        logic signed [15:0] cal_z;
        logic signed [15:0] top_x;
        logic signed [15:0] top_y;
        logic signed [15:0] top_z;
        logic signed [15:0] floor_x;
        logic signed [15:0] floor_y;
        logic signed [15:0] floor_z;
        logic               bad_range;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV, ST_DIVNEXT, ST_CORDIC, ST_DONE
    } state_t;

    // Request/response between the top level and the divider or the CORDIC.
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;

    localparam int ITERS     = 22;
    localparam int QBITS     = 15;   // quotient magnitude bits before saturation
    localparam logic signed [15:0] RST_TOP_X   = 16'sd258;
    localparam logic signed [15:0] RST_TOP_Y   = 16'sd228;
    localparam logic signed [15:0] RST_TOP_Z   = 16'sd294;
    localparam logic signed [15:0] RST_FLOOR_X = -16'sd244;
    localparam logic signed [15:0] RST_FLOOR_Y = -16'sd281;
    localparam logic signed [15:0] RST_FLOOR_Z = -16'sd210;
    localparam logic signed [31:0] HALF_TURN   = 32'sd5898240;
    localparam logic signed [31:0] FULL_TURN   = 32'sd11796480;
    localparam logic [15:0]        HEADING_WRAP = 16'd46080;

    // atan(2^-i) in 1/32768 degree
    function automatic logic [20:0] atan_lut(input logic [4:0] i);
        logic [20:0] r;
        begin
            unique case (i)
                5'd0:  r = 21'd1474560;
                5'd1:  r = 21'd870484;
                5'd2:  r = 21'd459940;
                5'd3:  r = 21'd233473;
                5'd4:  r = 21'd117189;
                5'd5:  r = 21'd58652;
                5'd6:  r = 21'd29333;
                5'd7:  r = 21'd14667;
                5'd8:  r = 21'd7334;
                5'd9:  r = 21'd3667;
                5'd10: r = 21'd1833;
                5'd11: r = 21'd917;
                5'd12: r = 21'd458;
                5'd13: r = 21'd229;
                5'd14: r = 21'd115;
                5'd15: r = 21'd57;
                5'd16: r = 21'd29;
                5'd17: r = 21'd14;
                5'd18: r = 21'd7;
                5'd19: r = 21'd4;
                5'd20: r = 21'd2;
                5'd21: r = 21'd1;
                default: r = 21'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// ----- rtl/mhc_divider.sv -----
// Restoring divider, one quotient bit per cycle, with round-half-up and
// saturation of the magnitude to 32768. Depends on mhc_pkg.
`timescale 1ns / 1ps
module mhc_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [17:0] mag,      // |2v - top - floor|
    input  logic [16:0] den,      // top - floor, > 0
    output logic [15:0] quot,     // rounded, saturated to 32767/32768 range
    output mhc_pkg::div_ctl_t ctl
);
    // dividend = mag*16384 + den, divisor = 2*den
    localparam int NB = 33;
    logic [NB-1:0] dvd_reg, dvd_next;
    logic [NB-1:0] rem_reg, rem_next;
    logic [NB-1:0] q_reg, q_next;
    logic [17:0]   dsr_reg, dsr_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [NB-1:0] trial;

    // one shift-subtract step per cycle
    always_comb begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[NB-2:0], dvd_reg[NB-1]};
        if (start) begin
            dvd_next  = {1'b0, mag, 14'd0} + {16'd0, den};
            rem_next  = '0;
            q_next    = '0;
            dsr_next  = {den, 1'b0};
            cnt_next  = 6'(NB);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[NB-2:0], 1'b0};
            if (trial >= {15'd0, dsr_reg}) begin
                rem_next = trial - {15'd0, dsr_reg};
                q_next   = {q_reg[NB-2:0], 1'b1};
            end else begin
                rem_next = trial;
                q_next   = {q_reg[NB-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        dsr_reg <= dsr_next;
    end

    // clamp magnitude to 32768 (caller trims positive side)
    assign quot     = (q_reg > 33'd32768) ? 16'd32768 : q_reg[15:0];
    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;
endmodule

// ----- rtl/mhc_cordic.sv -----
// Vectoring CORDIC, one micro-rotation per cycle through a shared adder pair.
// Produces heading in 1/128 degree. Depends on mhc_pkg.
`timescale 1ns / 1ps
module mhc_cordic (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [15:0] cal_x,
    input  logic signed [15:0] cal_y,
    output logic [15:0]        heading,
    output mhc_pkg::div_ctl_t  ctl
);
    logic signed [26:0] x_reg, x_next, y_reg, y_next;
    logic signed [31:0] ang_reg, ang_next;
    logic [4:0]         it_reg, it_next;
    logic               busy_reg, busy_next, done_reg, done_next, zero_reg, zero_next;
    logic signed [26:0] x0, y0, dx, dy;
    logic signed [31:0] a_fin;
    logic [23:0]        a_div;
    logic [15:0]        h_raw;

    always_comb begin
        x_next = x_reg; y_next = y_reg; ang_next = ang_reg; it_next = it_reg;
        busy_next = busy_reg; done_next = 1'b0; zero_next = zero_reg;
        x0 = -(27'(cal_x) <<< 8);
        y0 = 27'(cal_y) <<< 8;
        dx = y_reg >>> it_reg;
        dy = x_reg >>> it_reg;
        if (start) begin
            zero_next = (cal_x == 16'sd0) && (cal_y == 16'sd0);
            if (x0 < 0) begin
                x_next = -x0; y_next = -y0; ang_next = mhc_pkg::HALF_TURN;
            end else begin
                x_next = x0; y_next = y0; ang_next = '0;
            end
            it_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (y_reg > 0) begin
                x_next = x_reg + dx; y_next = y_reg - dy;
                ang_next = ang_reg + 32'(mhc_pkg::atan_lut(it_reg));
            end else begin
                x_next = x_reg - dx; y_next = y_reg + dy;
                ang_next = ang_reg - 32'(mhc_pkg::atan_lut(it_reg));
            end
            it_next = it_reg + 5'd1;
            if (it_reg == 5'(mhc_pkg::ITERS - 1)) begin
                busy_next = 1'b0; done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0; done_reg <= 1'b0; it_reg <= '0;
        end else begin
            busy_reg <= busy_next; done_reg <= done_next; it_reg <= it_next;
        end
        x_reg <= x_next; y_reg <= y_next; ang_reg <= ang_next; zero_reg <= zero_next;
    end

    // angle is positive after adding a full turn; /256 is a shift
    assign a_fin   = ang_reg + mhc_pkg::FULL_TURN + 32'sd128;
    assign a_div   = a_fin[31:8];
    assign h_raw   = a_div[15:0];
    // a_div lies below 2*46080, so one compare-subtract wraps it
    assign heading = zero_reg ? 16'd0 :
                     (a_div >= 24'(mhc_pkg::HEADING_WRAP)) ?
                     16'(a_div - 24'(mhc_pkg::HEADING_WRAP)) : h_raw;
    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;
endmodule

// ----- rtl/magnetometer_heading_calibrator_unit.sv -----
// Top level of the magnetometer heading calibrator: bound update, per-axis
// scaling through a shared serial divider, CORDIC heading. Uses mhc_pkg.
`timescale 1ns / 1ps
// One sample in, one result out. After its transfer an item runs through
// the axes in turn: each axis issues a divider start in ST_DIV, then 33
// divider steps, and the quotient is collected in ST_DIVNEXT (an axis with an
// empty range skips its division), then 22 CORDIC steps, after which ST_DONE
// loads the output register. The result sits in that register until taken.
// The next sample is accepted in the idle cycle after the load, so no new
// sample is taken while one is in flight; the input also stalls while a
// finished result finds the output register still full.
module magnetometer_heading_calibrator_unit #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  mhc_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output mhc_pkg::out_item_t m_data
);
    mhc_pkg::state_t state_reg, state_next;
    logic signed [15:0] top_reg [3], top_next [3];
    logic signed [15:0] flr_reg [3], flr_next [3];
    logic signed [15:0] v_reg [3];
    logic signed [15:0] cal_reg [3];
    logic [1:0]         ax_reg, ax_next;
    logic               bad_reg;
    logic               neg_reg;
    logic               mval_reg;
    mhc_pkg::out_item_t res_reg;
    logic               accept, div_start, cor_start, res_load;
    logic signed [15:0] raw [3];
    logic [15:0]        q;
    logic signed [17:0] num;
    logic signed [16:0] den;
    logic signed [15:0] cal_val;
    logic [15:0]        hd;
    mhc_pkg::div_ctl_t  dctl, cctl;

    // raw sample: low SAMPLE_WIDTH bits, sign-extended; index 0=x,1=y,2=z
    always_comb begin
        raw[0] = 16'($signed({s_data.x_high_byte, s_data.x_low_byte}
                  << (16 - SAMPLE_WIDTH)) >>> (16 - SAMPLE_WIDTH));
        raw[1] = 16'($signed({s_data.y_high_byte, s_data.y_low_byte}
                  << (16 - SAMPLE_WIDTH)) >>> (16 - SAMPLE_WIDTH));
        raw[2] = 16'($signed({s_data.z_high_byte, s_data.z_low_byte}
                  << (16 - SAMPLE_WIDTH)) >>> (16 - SAMPLE_WIDTH));
    end

    assign s_ready  = (state_reg == mhc_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    // finished result moves to the output register once it is free
    assign res_load = (state_reg == mhc_pkg::ST_DONE) && (!mval_reg || m_ready);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mhc_pkg::ST_IDLE:    if (accept) state_next = mhc_pkg::ST_DIV;
            mhc_pkg::ST_DIV:     state_next = mhc_pkg::ST_DIVNEXT;
            mhc_pkg::ST_DIVNEXT: if (dctl.done || den <= 0) begin
                if (ax_reg == 2'd2) state_next = mhc_pkg::ST_CORDIC;
                else state_next = mhc_pkg::ST_DIV;
            end
            mhc_pkg::ST_CORDIC:  if (cctl.done) state_next = mhc_pkg::ST_DONE;
            mhc_pkg::ST_DONE:    if (res_load) state_next = mhc_pkg::ST_IDLE;
            default:             state_next = mhc_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        div_start = 1'b0;
        cor_start = 1'b0;
        unique case (state_reg)
            mhc_pkg::ST_DIV:     div_start = (den > 0);
            mhc_pkg::ST_DIVNEXT: cor_start = (dctl.done || den <= 0) && (ax_reg == 2'd2);
            default: ;
        endcase
    end

    // operands of the current axis
    always_comb begin
        num = 18'(v_reg[ax_reg]) * 18'sd2 - 18'(top_reg[ax_reg]) - 18'(flr_reg[ax_reg]);
        den = 17'(top_reg[ax_reg]) - 17'(flr_reg[ax_reg]);
    end

    mhc_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .mag(num[17] ? 18'(-num) : 18'(num)),
        .den(17'(den)), .quot(q), .ctl(dctl)
    );

    // apply sign and saturation
    always_comb begin
        if (neg_reg) cal_val = 16'(-$signed({1'b0, q}));
        else cal_val = (q > 16'd32767) ? 16'sd32767 : $signed(q);
    end

    mhc_cordic u_cor (
        .aclk(aclk), .aresetn(aresetn), .start(cor_start),
        .cal_x(cal_reg[0]), .cal_y(cal_reg[1]), .heading(hd), .ctl(cctl)
    );

    // bound widening on accept when mode is set
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            top_next[i] = top_reg[i];
            flr_next[i] = flr_reg[i];
            if (accept && s_data.mode) begin
                if (raw[i] > top_reg[i]) top_next[i] = raw[i];
                if (raw[i] < flr_reg[i]) flr_next[i] = raw[i];
            end
        end
        ax_next = ax_reg;
        if (accept) ax_next = 2'd0;
        else if (state_reg == mhc_pkg::ST_DIVNEXT && (dctl.done || den <= 0)
                 && ax_reg != 2'd2)
            ax_next = ax_reg + 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mhc_pkg::ST_IDLE;
            mval_reg  <= 1'b0;
            ax_reg    <= '0;
            top_reg[0] <= mhc_pkg::RST_TOP_X;
            top_reg[1] <= mhc_pkg::RST_TOP_Y;
            top_reg[2] <= mhc_pkg::RST_TOP_Z;
            flr_reg[0] <= mhc_pkg::RST_FLOOR_X;
            flr_reg[1] <= mhc_pkg::RST_FLOOR_Y;
            flr_reg[2] <= mhc_pkg::RST_FLOOR_Z;
        end else begin
            state_reg <= state_next;
            ax_reg    <= ax_next;
            top_reg   <= top_next;
            flr_reg   <= flr_next;
            if (res_load) mval_reg <= 1'b1;
            else if (m_ready) mval_reg <= 1'b0;
        end
        if (accept) begin
            v_reg   <= raw;
            bad_reg <= 1'b0;
        end
        if (state_reg == mhc_pkg::ST_DIV) neg_reg <= num[17];
        if (state_reg == mhc_pkg::ST_DIVNEXT) begin
            if (den <= 0) begin
                cal_reg[ax_reg] <= '0;
                bad_reg <= 1'b1;
            end else if (dctl.done) begin
                cal_reg[ax_reg] <= cal_val;
            end
        end
        if (res_load) begin
            res_reg.heading   <= hd;
            res_reg.cal_x     <= cal_reg[0];
            res_reg.cal_y     <= cal_reg[1];
            res_reg.cal_z     <= cal_reg[2];
            res_reg.top_x     <= top_reg[0];
            res_reg.top_y     <= top_reg[1];
            res_reg.top_z     <= top_reg[2];
            res_reg.floor_x   <= flr_reg[0];
            res_reg.floor_y   <= flr_reg[1];
            res_reg.floor_z   <= flr_reg[2];
            res_reg.bad_range <= bad_reg;
        end
    end

    assign m_valid = mval_reg;
    assign m_data  = res_reg;
endmodule

// ----- rtl/mhc_checker.sv -----
// Port-level checks for the heading calibrator, bound to the top level.
// Depends on mhc_pkg.
`timescale 1ns / 1ps
module mhc_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input mhc_pkg::out_item_t m_data
);
    // pending result stays offered until taken
    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("result dropped");
    // heading always below a full turn
    a_heading_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.heading < 16'd46080) else $error("heading out of range");
    // unit is busy right after an input transfer
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready) else $error("input taken back to back");
    // held result stays stable
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_data)) else $error("result changed");
endmodule

bind magnetometer_heading_calibrator_unit mhc_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);

// ----- bench/magnetometer_heading_calibrator_unit_test.sv -----
// Testbench for magnetometer_heading_calibrator_unit: directed and random samples,
// checked field by field against an in-bench predictor. Depends on mhc_pkg and the RTL.
`timescale 1ns / 1ps
module magnetometer_heading_calibrator_unit_test;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    mhc_pkg::in_item_t  s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    mhc_pkg::out_item_t m_data;

    magnetometer_heading_calibrator_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #10 aclk = ~aclk;

    // Predictor state: stored per-axis bounds
    logic signed [15:0] hi_x, hi_y, hi_z, lo_x, lo_y, lo_z;
    mhc_pkg::out_item_t heading_queue[$];
    int errors = 0;
    int results_seen = 0;
    int sent = 0;
    int hold_cycles = 0;
    int rx_wait = 0;
    bit hold_request = 1'b0;
    bit rx_random = 1'b1;

    const longint ATAN_DEG[22] = '{1474560, 870484, 459940, 233473, 117189, 58652,
        29333, 14667, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};

    function automatic logic signed [15:0] scaled_axis(input logic signed [15:0] v,
            input logic signed [15:0] t, input logic signed [15:0] b, inout bit bad);
        longint den, num, mag, q;
        den = longint'(t) - longint'(b);
        num = 2 * longint'(v) - longint'(t) - longint'(b);
        if (den <= 0) begin
            bad = 1'b1;
            return 16'sd0;
        end
        mag = num < 0 ? -num : num;
        q = (mag * 16384 + den) / (2 * den);
        if (num < 0) begin
            q = -q;
            if (q < -32768) q = -32768;
        end else if (q > 32767) begin
            q = 32767;
        end
        return q[15:0];
    endfunction

    function automatic logic [15:0] cordic_heading(input logic signed [15:0] cx,
            input logic signed [15:0] cy);
        longint x, y, ang, dx, dy;
        x = -longint'(cx) * 256;
        y = longint'(cy) * 256;
        ang = 0;
        if (cx == 0 && cy == 0) return 16'd0;
        if (x < 0) begin
            x = -x;
            y = -y;
            ang = mhc_pkg::HALF_TURN;
        end
        for (int i = 0; i < 22; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; ang += ATAN_DEG[i];
            end else begin
                x -= dx; y += dy; ang -= ATAN_DEG[i];
            end
        end
        ang += mhc_pkg::FULL_TURN + 128;
        return 16'((ang / 256) % 46080);
    endfunction

    function automatic mhc_pkg::out_item_t predict_sample(input mhc_pkg::in_item_t s);
        mhc_pkg::out_item_t r;
        logic signed [15:0] vx, vy, vz;
        bit bad;
        bad = 1'b0;
        vx = {s.x_high_byte, s.x_low_byte};
        vy = {s.y_high_byte, s.y_low_byte};
        vz = {s.z_high_byte, s.z_low_byte};
        if (s.mode) begin
            if (vx > hi_x) hi_x = vx;
            if (vx < lo_x) lo_x = vx;
            if (vy > hi_y) hi_y = vy;
            if (vy < lo_y) lo_y = vy;
            if (vz > hi_z) hi_z = vz;
            if (vz < lo_z) lo_z = vz;
        end
        r.cal_x = scaled_axis(vx, hi_x, lo_x, bad);
        r.cal_y = scaled_axis(vy, hi_y, lo_y, bad);
        r.cal_z = scaled_axis(vz, hi_z, lo_z, bad);
        r.heading = cordic_heading(r.cal_x, r.cal_y);
        r.top_x = hi_x; r.top_y = hi_y; r.top_z = hi_z;
        r.floor_x = lo_x; r.floor_y = lo_y; r.floor_z = lo_z;
        r.bad_range = bad;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // Send one sample after a random gap; predicts at acceptance.
    // Valid stays up after the transfer until the next gap or a drain.
    task automatic send_sample(input mhc_pkg::in_item_t s, input bit gap = 1'b1);
        int idle;
        idle = gap ? int'($urandom_range(0, 4)) : 0;
        if (idle > 0) begin
            s_valid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= s;
        do @(posedge aclk); while (!s_ready);
        heading_queue.push_back(predict_sample(s));
        sent++;
    endtask

    function automatic mhc_pkg::in_item_t sample_of(input bit m, input logic [15:0] x,
            input logic [15:0] y, input logic [15:0] z);
        return {m, x, z, y};
    endfunction

    function automatic mhc_pkg::in_item_t random_sample(input bit m);
        mhc_pkg::in_item_t s;
        s = sample_of(m, 16'($urandom), 16'($urandom), 16'($urandom));
        // mostly magnetometer-sized values so headings vary inside the bounds
        if ($urandom_range(0, 3) != 0) begin
            s = sample_of(m, 16'($signed($urandom_range(0, 1200)) - 600),
                16'($signed($urandom_range(0, 1200)) - 600),
                16'($signed($urandom_range(0, 1200)) - 600));
        end
        return s;
    endfunction

    // Sender pauses until every expected result has come
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (heading_queue.size() != 0) @(posedge aclk);
    endtask

    // Result checker
    always @(posedge aclk) begin
        mhc_pkg::out_item_t w;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (heading_queue.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                w = heading_queue.pop_front();
                if (m_data.heading !== w.heading)
                    report_mismatch("heading", m_data.heading, w.heading);
                if (m_data.cal_x !== w.cal_x) report_mismatch("cal_x", m_data.cal_x, w.cal_x);
                if (m_data.cal_y !== w.cal_y) report_mismatch("cal_y", m_data.cal_y, w.cal_y);
                if (m_data.cal_z !== w.cal_z) report_mismatch("cal_z", m_data.cal_z, w.cal_z);
                if (m_data.top_x !== w.top_x) report_mismatch("top_x", m_data.top_x, w.top_x);
                if (m_data.top_y !== w.top_y) report_mismatch("top_y", m_data.top_y, w.top_y);
                if (m_data.top_z !== w.top_z) report_mismatch("top_z", m_data.top_z, w.top_z);
                if (m_data.floor_x !== w.floor_x)
                    report_mismatch("floor_x", m_data.floor_x, w.floor_x);
                if (m_data.floor_y !== w.floor_y)
                    report_mismatch("floor_y", m_data.floor_y, w.floor_y);
                if (m_data.floor_z !== w.floor_z)
                    report_mismatch("floor_z", m_data.floor_z, w.floor_z);
                if (m_data.bad_range !== w.bad_range)
                    report_mismatch("bad_range", m_data.bad_range, w.bad_range);
            end
        end
    end

    // Receiver: long hold on request, else, with rx_random set, a drawn random wait after each result
    always @(posedge aclk) begin
        int n;
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else if (hold_request) begin
            hold_request <= 1'b0;
            hold_cycles <= 800;
            m_ready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            m_ready <= 1'b0;
        end else if (rx_random && m_valid && m_ready) begin
            n = int'($urandom_range(0, 4));
            m_ready <= (n == 0);
            rx_wait <= (n == 0) ? 0 : n - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Extremes, zero vector and saturation at reset bounds
    task automatic test_directed();
        send_sample(sample_of(1'b0, 16'h0000, 16'h0000, 16'h0000));
        send_sample(sample_of(1'b0, 16'd5, 16'hFFE9, 16'd42));
        send_sample(sample_of(1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_sample(sample_of(1'b0, 16'h8000, 16'h8000, 16'h8000));
        send_sample(sample_of(1'b0, 16'hFFFF, 16'h00FF, 16'hFF00));
        send_sample(sample_of(1'b0, 16'd258, 16'hFEE7, 16'd294));
        send_sample(sample_of(1'b0, 16'hAAAA, 16'h5555, 16'h0F0F));
        send_sample(sample_of(1'b1, 16'd100, 16'hFF9C, 16'd0));
        send_sample(sample_of(1'b1, 16'h7FFF, 16'h8000, 16'h7FFF));
        send_sample(sample_of(1'b1, 16'h8000, 16'h7FFF, 16'h8000));
        send_sample(sample_of(1'b0, 16'h0000, 16'h0000, 16'h0000));
        send_sample(sample_of(1'b0, 16'h4000, 16'hC000, 16'h1234));
        for (int i = 0; i < 8; i++) begin
            send_sample(sample_of(1'b0, 16'($signed(i * 9000 - 32768)),
                16'($signed(32767 - i * 8000)), 16'($urandom)));
        end
    endtask

    // Random measure and calibrate samples with idling on both sides
    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) begin
            send_sample(random_sample(($urandom_range(0, 9) == 0)));
        end
    endtask

    // Receiver holds off while the sender keeps offering samples
    task automatic test_backpressure();
        hold_request = 1'b1;
        for (int i = 0; i < 8; i++) send_sample(random_sample(1'b0), 1'b0);
        wait_drained();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        {hi_x, hi_y, hi_z} = {mhc_pkg::RST_TOP_X, mhc_pkg::RST_TOP_Y, mhc_pkg::RST_TOP_Z};
        {lo_x, lo_y, lo_z} = {mhc_pkg::RST_FLOOR_X, mhc_pkg::RST_FLOOR_Y,
                              mhc_pkg::RST_FLOOR_Z};
        test_directed();
        wait_drained();
        test_random(700);
        test_backpressure();
        rx_random = 1'b0;
        test_random(200);
        wait_drained();
        rx_random = 1'b1;
        test_random(650);
        wait_drained();
        repeat (300) @(posedge aclk);
        $display("covered %0d samples, %0d results, measure and calibrate modes, stalls",
            sent, results_seen);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Timeout guard
    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule
